// ===== rtl/msgc_pkg.sv =====
// ----------------------------------------------------------------------------
// msgc_pkg
// Shared widths, register indexes and types of the multi-stop gradient block.
// ----------------------------------------------------------------------------
package msgc_pkg;

	localparam int FRAC_BITS  = 12;
	localparam int T_W        = FRAC_BITS + 1;
	localparam int POS_W      = 13;
	localparam int REG_STOPS  = 4;
	localparam int MAX_STOPS  = 4;
	localparam int N_LIM      = (MAX_STOPS < REG_STOPS) ? MAX_STOPS : REG_STOPS;
	localparam int CNT_W      = 3;
	localparam int COL_W      = 32;
	localparam int CH_W       = 8;
	localparam int N_CH       = 4;
	localparam int POSREG_W   = POS_W * REG_STOPS;
	localparam int CFG_W      = 64;
	localparam int IDX_W      = 3;
	localparam int IN_W       = 16;
	localparam int OUT_W      = N_CH * CH_W;
	localparam int PROD_W     = CH_W + T_W;
	localparam int DIV_SLICES = 4;
	localparam int SLICE_STEPS = FRAC_BITS / DIV_SLICES;
	localparam int N_STAGES   = 9;

	localparam logic [T_W-1:0] ONE = T_W'(1 << FRAC_BITS);

	typedef enum logic [IDX_W-1:0] {
		REG_STOP_COUNT     = 3'd0,
		REG_START_COLOR    = 3'd1,
		REG_END_COLOR      = 3'd2,
		REG_STOP_POSITIONS = 3'd3,
		REG_STOP_COLORS_LO = 3'd4,
		REG_STOP_COLORS_HI = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [POS_W-1:0] rem;
		logic [T_W-1:0]   quo;
	} div_t;

endpackage

// ===== rtl/msgc_div_slice.sv =====
// ----------------------------------------------------------------------------
// msgc_div_slice
// A few restoring division steps: shift the remainder, subtract the divisor
// where it fits and shift the quotient bit in from the bottom.
// ----------------------------------------------------------------------------
module msgc_div_slice #(
	parameter int STEPS = msgc_pkg::SLICE_STEPS
) (
	input  msgc_pkg::div_t                  acc,
	input  logic [msgc_pkg::POS_W-1:0]      den,
	output msgc_pkg::div_t                  res
);

	always_comb begin
		msgc_pkg::div_t           r;
		logic [msgc_pkg::POS_W:0] r2;
		r = acc;
		for (int s = 0; s < STEPS; s++) begin
			r2 = {r.rem, 1'b0};
			if (r2 >= {1'b0, den}) begin
				r2    = r2 - {1'b0, den};
				r.rem = r2[msgc_pkg::POS_W-1:0];
				r.quo = {r.quo[msgc_pkg::T_W-2:0], 1'b1};
			end else begin
				r.rem = r2[msgc_pkg::POS_W-1:0];
				r.quo = {r.quo[msgc_pkg::T_W-2:0], 1'b0};
			end
		end
		res = r;
	end

endmodule

// ===== rtl/multi_stop_gradient_color_top.sv =====
// ----------------------------------------------------------------------------
// multi_stop_gradient_color_top
// Multi-stop colour gradient lookup, one position in and one RGBA colour out.
// ----------------------------------------------------------------------------
// Input stream s_axis carries a signed Q12 position; it is clamped to 0..1.0.
// Output stream m_axis carries red, green, blue, alpha of the colour.
// The configuration port writes stop count, start/end colours, stop positions
// and stop colours; write only while no word is in flight.
// With no stops the colour blends start to end, with one stop it is that
// stop's colour, otherwise the first enclosing pair of stops is blended, or
// the last stop's colour is taken when no pair encloses the position.
// Throughput is one word per cycle while the receiver is ready; the nine
// stages (clamp, compare, select, four stages of three restoring division
// steps, multiply, sum) are set by the 12-bit blend factor division.
// Each stage holds its word while the stage after it is full and stalled, so
// bubbles are squeezed out and a stalled receiver loses and repeats nothing.
// Reset empties the pipeline and sets end colour to all ones, every other
// configuration register to zero.
// ----------------------------------------------------------------------------
module multi_stop_gradient_color_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [msgc_pkg::IN_W-1:0]     s_axis_tdata,   // position
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [msgc_pkg::OUT_W-1:0]    m_axis_tdata,   // red, green, blue, alpha
	input  logic                          cfg_wen,
	input  logic [msgc_pkg::IDX_W-1:0]    cfg_index,
	input  logic [msgc_pkg::CFG_W-1:0]    cfg_data
);

	localparam int NS = msgc_pkg::N_STAGES;
	localparam int TW = msgc_pkg::T_W;
	localparam int PW = msgc_pkg::POS_W;
	localparam int CW = msgc_pkg::COL_W;
	localparam int HW = msgc_pkg::CH_W;
	localparam int NC = msgc_pkg::N_CH;
	localparam int RS = msgc_pkg::REG_STOPS;
	localparam int QW = msgc_pkg::PROD_W;

	logic [msgc_pkg::CNT_W-1:0]    stop_count_q;
	logic [CW-1:0]                 start_color_q;
	logic [CW-1:0]                 end_color_q;
	logic [msgc_pkg::POSREG_W-1:0] stop_positions_q;
	logic [msgc_pkg::CFG_W-1:0]    stop_colors_lo_q;
	logic [msgc_pkg::CFG_W-1:0]    stop_colors_hi_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stop_count_q     <= '0;
			start_color_q    <= '0;
			end_color_q      <= '1;
			stop_positions_q <= '0;
			stop_colors_lo_q <= '0;
			stop_colors_hi_q <= '0;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				msgc_pkg::REG_STOP_COUNT:     stop_count_q     <= cfg_data[msgc_pkg::CNT_W-1:0];
				msgc_pkg::REG_START_COLOR:    start_color_q    <= cfg_data[CW-1:0];
				msgc_pkg::REG_END_COLOR:      end_color_q      <= cfg_data[CW-1:0];
				msgc_pkg::REG_STOP_POSITIONS:
					stop_positions_q <= cfg_data[msgc_pkg::POSREG_W-1:0];
				msgc_pkg::REG_STOP_COLORS_LO: stop_colors_lo_q <= cfg_data;
				msgc_pkg::REG_STOP_COLORS_HI: stop_colors_hi_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic [PW-1:0] pos   [RS];
	logic [CW-1:0] col   [RS];
	logic [msgc_pkg::CNT_W-1:0] n_eff;

	always_comb begin
		for (int k = 0; k < RS; k++) begin
			pos[k] = stop_positions_q[k*PW +: PW];
		end
		col[0] = stop_colors_lo_q[CW-1:0];
		col[1] = stop_colors_lo_q[2*CW-1:CW];
		col[2] = stop_colors_hi_q[CW-1:0];
		col[3] = stop_colors_hi_q[2*CW-1:CW];
		if (stop_count_q > msgc_pkg::CNT_W'(msgc_pkg::N_LIM)) begin
			n_eff = msgc_pkg::CNT_W'(msgc_pkg::N_LIM);
		end else begin
			n_eff = stop_count_q;
		end
	end

	// per-stage advance chain
	logic [NS-1:0] valid_q;
	logic [NS-1:0] en;

	always_comb begin
		en[NS-1] = !valid_q[NS-1] || m_axis_tready;
		for (int k = NS-2; k >= 0; k--) begin
			en[k] = !valid_q[k] || en[k+1];
		end
	end

	assign s_axis_tready = en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (en[0]) valid_q[0] <= s_axis_tvalid;
			for (int k = 1; k < NS; k++) begin
				if (en[k]) valid_q[k] <= valid_q[k-1];
			end
		end
	end

	// stage 1: clamp
	logic [TW-1:0] t_s1;
	logic [TW-1:0] t_clamp;

	always_comb begin
		if (s_axis_tdata[msgc_pkg::IN_W-1]) begin
			t_clamp = '0;
		end else if (s_axis_tdata[msgc_pkg::IN_W-2:0] > (msgc_pkg::IN_W-1)'(msgc_pkg::ONE)) begin
			t_clamp = msgc_pkg::ONE;
		end else begin
			t_clamp = s_axis_tdata[TW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) t_s1 <= t_clamp;
	end

	// stage 2: pair compares
	logic [TW-1:0] t_s2;
	logic [RS-2:0] match_s2;
	logic [RS-2:0] match_d;

	always_comb begin
		for (int i = 0; i < RS-1; i++) begin
			match_d[i] = (msgc_pkg::CNT_W'(i + 1) < n_eff)
				&& ({1'b0, t_s1} >= {1'b0, pos[i]}) && ({1'b0, t_s1} <= {1'b0, pos[i+1]});
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			t_s2     <= t_s1;
			match_s2 <= match_d;
		end
	end

	// stage 3: pick the colours and the division operands
	logic [CW-1:0] ca_s3, cb_s3;
	logic [PW-1:0] num_s3, den_s3;
	logic [CW-1:0] ca_d, cb_d;
	logic [PW-1:0] num_d, den_d;

	always_comb begin
		logic [1:0]    sel;
		logic          hit;
		logic [PW-1:0] lo, hi, rng;
		sel = '0;
		hit = 1'b0;
		for (int i = RS-2; i >= 0; i--) begin
			if (match_s2[i]) begin
				sel = 2'(i);
				hit = 1'b1;
			end
		end
		lo  = pos[sel];
		hi  = pos[sel + 2'd1];
		rng = hi - lo;
		priority if (n_eff == '0) begin
			ca_d  = start_color_q;
			cb_d  = end_color_q;
			num_d = PW'(t_s2);
			den_d = PW'(msgc_pkg::ONE);
		end else if (n_eff == msgc_pkg::CNT_W'(1)) begin
			ca_d  = col[0];
			cb_d  = col[0];
			num_d = '0;
			den_d = PW'(1);
		end else if (hit && rng == '0) begin
			ca_d  = col[sel];
			cb_d  = col[sel];
			num_d = '0;
			den_d = PW'(1);
		end else if (hit) begin
			ca_d  = col[sel];
			cb_d  = col[sel + 2'd1];
			num_d = PW'(t_s2) - lo;
			den_d = rng;
		end else begin
			ca_d  = col[2'(n_eff - msgc_pkg::CNT_W'(1))];
			cb_d  = col[2'(n_eff - msgc_pkg::CNT_W'(1))];
			num_d = '0;
			den_d = PW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			ca_s3  <= ca_d;
			cb_s3  <= cb_d;
			num_s3 <= num_d;
			den_s3 <= den_d;
		end
	end

	// stages 4 to 7: blend factor division, three steps a stage
	msgc_pkg::div_t div_init;
	msgc_pkg::div_t div_n4, div_n5, div_n6, div_n7;
	msgc_pkg::div_t div_s4, div_s5, div_s6, div_s7;
	logic [PW-1:0]  den_s4, den_s5, den_s6;
	logic [CW-1:0]  ca_s4, ca_s5, ca_s6, ca_s7;
	logic [CW-1:0]  cb_s4, cb_s5, cb_s6, cb_s7;

	always_comb begin
		if (num_s3 == den_s3) begin
			div_init.rem = '0;
			div_init.quo = TW'(1);
		end else begin
			div_init.rem = num_s3;
			div_init.quo = '0;
		end
	end

	msgc_div_slice #(.STEPS(msgc_pkg::SLICE_STEPS)) u_div0 (
		.acc (div_init), .den (den_s3), .res (div_n4)
	);
	msgc_div_slice #(.STEPS(msgc_pkg::SLICE_STEPS)) u_div1 (
		.acc (div_s4), .den (den_s4), .res (div_n5)
	);
	msgc_div_slice #(.STEPS(msgc_pkg::SLICE_STEPS)) u_div2 (
		.acc (div_s5), .den (den_s5), .res (div_n6)
	);
	msgc_div_slice #(.STEPS(msgc_pkg::SLICE_STEPS)) u_div3 (
		.acc (div_s6), .den (den_s6), .res (div_n7)
	);

	always_ff @(posedge clk) begin
		if (en[3]) begin
			div_s4 <= div_n4;
			den_s4 <= den_s3;
			ca_s4  <= ca_s3;
			cb_s4  <= cb_s3;
		end
		if (en[4]) begin
			div_s5 <= div_n5;
			den_s5 <= den_s4;
			ca_s5  <= ca_s4;
			cb_s5  <= cb_s4;
		end
		if (en[5]) begin
			div_s6 <= div_n6;
			den_s6 <= den_s5;
			ca_s6  <= ca_s5;
			cb_s6  <= cb_s5;
		end
		if (en[6]) begin
			div_s7 <= div_n7;
			ca_s7  <= ca_s6;
			cb_s7  <= cb_s6;
		end
	end

	// stage 8: channel products
	logic [QW-1:0] pa_s8 [NC];
	logic [QW-1:0] pb_s8 [NC];

	always_ff @(posedge clk) begin
		if (en[7]) begin
			for (int ch = 0; ch < NC; ch++) begin
				pa_s8[ch] <= QW'(ca_s7[CW-1-HW*ch -: HW]) * QW'(msgc_pkg::ONE - div_s7.quo);
				pb_s8[ch] <= QW'(cb_s7[CW-1-HW*ch -: HW]) * QW'(div_s7.quo);
			end
		end
	end

	// stage 9: sum, truncate and hold for the receiver
	logic [msgc_pkg::OUT_W-1:0] out_s9;
	logic [msgc_pkg::OUT_W-1:0] out_d;

	always_comb begin
		logic [QW:0] sum;
		for (int ch = 0; ch < NC; ch++) begin
			sum = {1'b0, pa_s8[ch]} + {1'b0, pb_s8[ch]};
			out_d[HW*ch +: HW] = sum[msgc_pkg::FRAC_BITS +: HW];
		end
	end

	always_ff @(posedge clk) begin
		if (en[8]) out_s9 <= out_d;
	end

	assign m_axis_tvalid = valid_q[NS-1];
	assign m_axis_tdata  = out_s9;

endmodule
